// ===== design/hsv2rgb_pkg.sv =====
// hsv2rgb_pkg: field widths, scale constants and sector codes for the hsv to rgb core
// no dependencies; imported by hsv_to_rgb_converter_core
`default_nettype none

package hsv2rgb_pkg;

  // field widths
  localparam int unsigned HueW   = 15;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned RemW   = 12;
  localparam int unsigned NumW   = 20;
  localparam int unsigned ProdW  = NumW + ChanW;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 24;

  // hue scale in 1/64 degree
  localparam logic [HueW-1:0] HueFullTurn = 15'd23040;
  localparam logic [RemW-1:0] HueSector   = 12'd3840;
  localparam logic [ChanW-1:0] SatFull    = 8'd255;
  localparam logic [NumW-1:0] QtScale     = 20'd979200;

  // reciprocals: floor(y / d) = (y * M) >> RecipShift for the ranges used here
  localparam int unsigned RecipShift = 28;
  localparam logic [24:0] Recip15  = 25'd17895698;
  localparam logic [20:0] Recip255 = 21'd1052689;

  // hexcone sectors
  typedef enum logic [2:0] {
    SECT_RED_YELLOW,
    SECT_YELLOW_GREEN,
    SECT_GREEN_CYAN,
    SECT_CYAN_BLUE,
    SECT_BLUE_MAGENTA,
    SECT_MAGENTA_RED
  } sector_e;

  // hue offset of the start of each sector
  function automatic logic [HueW-1:0] sector_base(input sector_e sect);
    logic [HueW-1:0] base;
    case (sect)
      SECT_RED_YELLOW:   base = 15'd0;
      SECT_YELLOW_GREEN: base = 15'd3840;
      SECT_GREEN_CYAN:   base = 15'd7680;
      SECT_CYAN_BLUE:    base = 15'd11520;
      SECT_BLUE_MAGENTA: base = 15'd15360;
      SECT_MAGENTA_RED:  base = 15'd19200;
      default:           base = 15'd0;
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// ===== design/hsv_to_rgb_converter_core.sv =====
// hsv_to_rgb_converter_core: five-stage pipelined hsv to 8-bit rgb converter
// depends on hsv2rgb_pkg for widths, scale constants and sector codes
`default_nettype none

// Usage
//   input item on s_axis: hue (1/64 degree), saturation, brightness packed in tdata.
//   result item on m_axis: red, green, blue packed in tdata.
//   one result item per input item, in order.
// Path: an item is registered in each of the stages below in turn; m_axis_tvalid_o
//   rises when it reaches the last one, the output register.
// Throughput: one item per cycle unless stalled; five register stages (sector
//   split, saturation products, brightness products, divide by 15, divide by
//   255 with sector select) all advance together.
// Stall: when the output holds a result that m_axis_tready_i does not take,
//   the whole pipe freezes and s_axis_tready_o drops; nothing is lost or
//   repeated. While the output stage is empty or being taken, an item is
//   accepted every cycle.
// Hue of 23040 or above is treated as zero. Bit 31 of s_axis_tdata_i is unused.
// Reset: rst_ni clears all valid bits; the data registers are not reset.
module hsv_to_rgb_converter_core
  import hsv2rgb_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [14:0] hue, [22:15] saturation, [30:23] brightness, [31] zero
  input  wire logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [OutTdataW-1:0]      m_axis_tdata_o
);

  logic en;
  logic [4:0] vld_q, vld_d;

  // pipe advances unless the output holds an untaken result
  assign en = ~vld_q[4] | m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[4];

  // valid bits
  assign vld_d = {vld_q[3:0], s_axis_tvalid_i};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // stage 1: hue clamp, sector and remainder
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] sat, bri;
  sector_e          sect;
  logic [HueW-1:0]  rem_full;

  assign sat = s_axis_tdata_i[22:15];
  assign bri = s_axis_tdata_i[30:23];

  always_comb begin
    hue = s_axis_tdata_i[14:0];
    if (hue >= HueFullTurn) begin
      hue = '0;
    end
    if (hue < 15'd3840) begin
      sect = SECT_RED_YELLOW;
    end else if (hue < 15'd7680) begin
      sect = SECT_YELLOW_GREEN;
    end else if (hue < 15'd11520) begin
      sect = SECT_GREEN_CYAN;
    end else if (hue < 15'd15360) begin
      sect = SECT_CYAN_BLUE;
    end else if (hue < 15'd19200) begin
      sect = SECT_BLUE_MAGENTA;
    end else begin
      sect = SECT_MAGENTA_RED;
    end
    rem_full = hue - sector_base(sect);
  end

  sector_e          s1_sect_q;
  logic [RemW-1:0]  s1_rem_q;
  logic [ChanW-1:0] s1_sat_q, s1_np_q, s1_bri_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sect_q <= sect;
      s1_rem_q  <= rem_full[RemW-1:0];
      s1_sat_q  <= sat;
      s1_np_q   <= SatFull - sat;
      s1_bri_q  <= bri;
    end
  end

  // stage 2: saturation products and q/t numerators
  logic [NumW-1:0] sr_prod, st_prod;
  logic [RemW-1:0] rem_inv;

  assign rem_inv = HueSector - s1_rem_q;
  assign sr_prod = NumW'(s1_sat_q) * NumW'(s1_rem_q);
  assign st_prod = NumW'(s1_sat_q) * NumW'(rem_inv);

  sector_e          s2_sect_q;
  logic [NumW-1:0]  s2_nq_q, s2_nt_q;
  logic [ChanW-1:0] s2_np_q, s2_bri_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sect_q <= s1_sect_q;
      s2_nq_q   <= QtScale - sr_prod;
      s2_nt_q   <= QtScale - st_prod;
      s2_np_q   <= s1_np_q;
      s2_bri_q  <= s1_bri_q;
    end
  end

  // stage 3: brightness times each numerator
  sector_e           s3_sect_q;
  logic [ProdW-1:0]  s3_xq_q, s3_xt_q;
  logic [2*ChanW-1:0] s3_xp_q;
  logic [ChanW-1:0]  s3_bri_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_sect_q <= s2_sect_q;
      s3_xq_q   <= ProdW'(s2_bri_q) * ProdW'(s2_nq_q);
      s3_xt_q   <= ProdW'(s2_bri_q) * ProdW'(s2_nt_q);
      s3_xp_q   <= (2*ChanW)'(s2_bri_q) * (2*ChanW)'(s2_np_q);
      s3_bri_q  <= s2_bri_q;
    end
  end

  // stage 4: divide q/t products by 3840 (shift by 256, then reciprocal of 15)
  logic [44:0] dq_prod, dt_prod;

  assign dq_prod = 45'(s3_xq_q[ProdW-1:8]) * 45'(Recip15);
  assign dt_prod = 45'(s3_xt_q[ProdW-1:8]) * 45'(Recip15);

  sector_e            s4_sect_q;
  logic [16:0]        s4_yq_q, s4_yt_q;
  logic [2*ChanW-1:0] s4_xp_q;
  logic [ChanW-1:0]   s4_bri_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_sect_q <= s3_sect_q;
      s4_yq_q   <= dq_prod[RecipShift+16:RecipShift];
      s4_yt_q   <= dt_prod[RecipShift+16:RecipShift];
      s4_xp_q   <= s3_xp_q;
      s4_bri_q  <= s3_bri_q;
    end
  end

  // stage 5: divide by 255 and sector select
  logic [37:0] eq_prod, et_prod, ep_prod;
  logic [ChanW-1:0] q_val, t_val, p_val;
  logic [ChanW-1:0] red, green, blue;

  assign eq_prod = 38'(s4_yq_q) * 38'(Recip255);
  assign et_prod = 38'(s4_yt_q) * 38'(Recip255);
  assign ep_prod = 38'(s4_xp_q) * 38'(Recip255);
  assign q_val = eq_prod[RecipShift+ChanW-1:RecipShift];
  assign t_val = et_prod[RecipShift+ChanW-1:RecipShift];
  assign p_val = ep_prod[RecipShift+ChanW-1:RecipShift];

  always_comb begin
    case (s4_sect_q)
      SECT_RED_YELLOW: begin
        red = s4_bri_q; green = t_val; blue = p_val;
      end
      SECT_YELLOW_GREEN: begin
        red = q_val; green = s4_bri_q; blue = p_val;
      end
      SECT_GREEN_CYAN: begin
        red = p_val; green = s4_bri_q; blue = t_val;
      end
      SECT_CYAN_BLUE: begin
        red = p_val; green = q_val; blue = s4_bri_q;
      end
      SECT_BLUE_MAGENTA: begin
        red = t_val; green = p_val; blue = s4_bri_q;
      end
      default: begin
        red = s4_bri_q; green = p_val; blue = q_val;
      end
    endcase
  end

  logic [OutTdataW-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {blue, green, red};
    end
  end

  assign m_axis_tdata_o = out_q;

endmodule

`default_nettype wire
